[rtl/core/knnsm_pkg.sv]
`timescale 1ns / 1ps
// Shared constants and types for the 3x3 k-smallest mean filter.
package knnsm_pkg;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT) + 1;
    localparam int SUM_W      = 12;
    localparam int DIV_STEPS  = SUM_W;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_K      = 2'd2;

    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_SUM,
        ST_DIV,
        ST_HOLD
    } state_t;
endpackage

[rtl/core/knn_smallest_mean_filter_3x3.sv]
`timescale 1ns / 1ps
// Top level: 3x3 k-smallest mean filter with line memory and shared sum/divide sequencer.
//
//  channel | signals                          | payload
//  input   | s_tvalid s_tready s_tdata s_tuser| pixel, action (flush flag)
//  result  | m_tvalid m_tready m_tdata m_tlast| filtered, frame_last
//  config  | cfg_wr_en cfg_index cfg_wdata    | width, height, k_count
//
// A flush before the frame's pixels are all in is dropped without leaving idle.
// Any other item goes through the line memory read, the window update,
// the ranking and adding of the window values, the restoring divide and
// the output register load; the last three only if a result follows.
// Reset is synchronous; the line memory needs no clearing. A stalled result
// waits in the output register while the next item is already taken in.
module knn_smallest_mean_filter_3x3 (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] pixel
    input  logic        s_tuser,   // [0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] filtered
    output logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_wdata
);
    localparam int CW = knnsm_pkg::COL_W;
    localparam int RW = knnsm_pkg::ROW_W;

    knnsm_pkg::state_t state_reg, state_next;

    logic [10:0] width_reg;
    logic [12:0] height_reg;
    logic [3:0]  k_reg;

    logic [CW-1:0] in_col_reg, out_col_reg;
    logic [RW-1:0] in_row_reg;
    logic [11:0]   out_row_reg;

    logic [7:0]  win_reg [9];
    logic [7:0]  nine_reg [9];

    logic [15:0] line_mem [knnsm_pkg::MAX_WIDTH];
    logic [15:0] rd_data_reg;

    logic [CW-1:0] ci_reg;
    logic [7:0]    pix_reg;
    logic          drain_reg;
    logic          row0_reg, row1_reg, lastcol_reg;

    logic [3:0]          idx_reg;
    logic [knnsm_pkg::SUM_W-1:0] acc_reg;
    logic [knnsm_pkg::SUM_W-1:0] quo_reg;
    logic [3:0]          rem_reg;
    logic                flast_reg;

    logic [7:0] m_data_reg;
    logic       m_last_reg, m_valid_reg;

    // clamped configuration
    logic [10:0] w_eff;
    logic [12:0] h_eff;
    logic [3:0]  k_eff;
    assign w_eff = (width_reg == 11'd0) ? 11'd1 :
                   (width_reg > 11'(knnsm_pkg::MAX_WIDTH)) ? 11'(knnsm_pkg::MAX_WIDTH) :
                   width_reg;
    assign h_eff = (height_reg == 13'd0) ? 13'd1 :
                   (height_reg > 13'(knnsm_pkg::MAX_HEIGHT)) ?
                   13'(knnsm_pkg::MAX_HEIGHT) : height_reg;
    assign k_eff = (k_reg == 4'd0) ? 4'd1 : (k_reg > 4'd9) ? 4'd9 : k_reg;

    logic          accept;
    logic [CW-1:0] c_cl;
    logic          in_frame;
    logic          drop;
    assign s_tready = (state_reg == knnsm_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign c_cl     = ({1'b0, in_col_reg} >= w_eff) ? CW'(w_eff - 11'd1) : in_col_reg;
    assign in_frame = ({1'b0, in_row_reg} < {1'b0, h_eff});
    assign drop     = in_frame && (s_tuser == knnsm_pkg::ACT_FLUSH);

    // window update in CALC
    logic [7:0] mid_v, above_v, v_v, top_v;
    logic [7:0] nwin [9];
    logic [7:0] nine_c [9];
    logic       out_lastcol, has_out, frame_end;
    assign above_v = rd_data_reg[15:8];
    assign mid_v   = rd_data_reg[7:0];
    assign v_v     = drain_reg ? mid_v : pix_reg;
    assign top_v   = row0_reg ? v_v : (row1_reg ? mid_v : above_v);
    assign out_lastcol = ({1'b0, out_col_reg} + 11'd1 >= w_eff);
    assign has_out  = !(row0_reg || (row1_reg && ci_reg == '0));
    assign frame_end = out_lastcol && ({1'b0, out_row_reg} + 13'd1 >= h_eff);

    always_comb begin
        for (int i = 0; i < 6; i++) nwin[i] = win_reg[i+3];
        nwin[6] = top_v;
        // on the first row the middle row repeats the pixel itself
        nwin[7] = row0_reg ? v_v : mid_v;
        nwin[8] = v_v;
        for (int i = 0; i < 3; i++) begin
            if (out_lastcol) begin
                nine_c[i]   = (w_eff == 11'd1) ? win_reg[i+6] : win_reg[i+3];
                nine_c[i+3] = win_reg[i+6];
                nine_c[i+6] = win_reg[i+6];
            end else begin
                nine_c[i]   = (out_col_reg == '0) ? nwin[i+3] : nwin[i];
                nine_c[i+3] = nwin[i+3];
                nine_c[i+6] = nwin[i+6];
            end
        end
    end

    // rank of the selected window value in a stable sort
    logic [7:0] cur_v;
    logic [3:0] rank;
    assign cur_v = nine_reg[idx_reg];
    always_comb begin
        rank = 4'd0;
        for (int j = 0; j < 9; j++) begin
            if ((nine_reg[j] < cur_v) || (nine_reg[j] == cur_v && 4'(j) < idx_reg))
                rank = rank + 4'd1;
        end
    end

    // restoring divide step
    logic [4:0] trial;
    logic       qbit;
    assign trial = {rem_reg, quo_reg[knnsm_pkg::SUM_W-1]};
    assign qbit  = (trial >= {1'b0, k_eff});

    logic out_free;
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            knnsm_pkg::ST_IDLE: if (accept && !drop) state_next = knnsm_pkg::ST_CALC;
            knnsm_pkg::ST_CALC: state_next = has_out ? knnsm_pkg::ST_SUM : knnsm_pkg::ST_IDLE;
            knnsm_pkg::ST_SUM:  if (idx_reg == 4'd8) state_next = knnsm_pkg::ST_DIV;
            knnsm_pkg::ST_DIV:
                if (idx_reg == 4'(knnsm_pkg::DIV_STEPS - 1)) state_next = knnsm_pkg::ST_HOLD;
            knnsm_pkg::ST_HOLD: if (out_free) state_next = knnsm_pkg::ST_IDLE;
            default: state_next = knnsm_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= knnsm_pkg::ST_IDLE;
        else state_reg <= state_next;
    end

    // line memory: above row in the high byte, middle row in the low byte
    always_ff @(posedge aclk) begin
        if (accept) rd_data_reg <= line_mem[c_cl];
        if (state_reg == knnsm_pkg::ST_CALC) line_mem[ci_reg] <= {mid_v, v_v};
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            ci_reg      <= c_cl;
            pix_reg     <= s_tdata;
            drain_reg   <= !in_frame;
            row0_reg    <= (in_row_reg == '0);
            row1_reg    <= (in_row_reg == RW'(1));
            lastcol_reg <= ({1'b0, c_cl} + 11'd1 >= w_eff);
        end
        if (state_reg == knnsm_pkg::ST_CALC) begin
            for (int i = 0; i < 9; i++) nine_reg[i] <= nine_c[i];
            flast_reg <= frame_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= 11'd1024;
            height_reg  <= 13'd1024;
            k_reg       <= 4'd5;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            for (int i = 0; i < 9; i++) win_reg[i] <= 8'd0;
            idx_reg     <= '0;
            acc_reg     <= '0;
            quo_reg     <= '0;
            rem_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    knnsm_pkg::CFG_WIDTH: begin
                        width_reg <= cfg_wdata[10:0];
                        in_col_reg <= '0; in_row_reg <= '0;
                        out_col_reg <= '0; out_row_reg <= '0;
                    end
                    knnsm_pkg::CFG_HEIGHT: begin
                        height_reg <= cfg_wdata;
                        in_col_reg <= '0; in_row_reg <= '0;
                        out_col_reg <= '0; out_row_reg <= '0;
                    end
                    knnsm_pkg::CFG_K: k_reg <= cfg_wdata[3:0];
                    default: ;
                endcase
            end
            // the output load refills the register itself
            if (m_valid_reg && m_tready && state_reg != knnsm_pkg::ST_HOLD)
                m_valid_reg <= 1'b0;
            case (state_reg)
                knnsm_pkg::ST_CALC: begin
                    for (int i = 0; i < 9; i++) win_reg[i] <= nwin[i];
                    idx_reg <= '0;
                    acc_reg <= '0;
                    if (has_out && frame_end) begin
                        in_col_reg <= '0; in_row_reg <= '0;
                        out_col_reg <= '0; out_row_reg <= '0;
                    end else begin
                        if (lastcol_reg) begin
                            in_col_reg <= '0;
                            in_row_reg <= in_row_reg + RW'(1);
                        end else begin
                            in_col_reg <= ci_reg + CW'(1);
                        end
                        if (has_out) begin
                            if (out_lastcol) begin
                                out_col_reg <= '0;
                                out_row_reg <= out_row_reg + 12'd1;
                            end else begin
                                out_col_reg <= out_col_reg + CW'(1);
                            end
                        end
                    end
                end
                knnsm_pkg::ST_SUM: begin
                    if (rank < k_eff) acc_reg <= acc_reg + {4'd0, cur_v};
                    if (idx_reg == 4'd8) begin
                        idx_reg <= '0;
                        quo_reg <= (rank < k_eff) ? acc_reg + {4'd0, cur_v} : acc_reg;
                        rem_reg <= '0;
                    end else begin
                        idx_reg <= idx_reg + 4'd1;
                    end
                end
                knnsm_pkg::ST_DIV: begin
                    rem_reg <= qbit ? 4'(trial - {1'b0, k_eff}) : trial[3:0];
                    quo_reg <= {quo_reg[knnsm_pkg::SUM_W-2:0], qbit};
                    idx_reg <= idx_reg + 4'd1;
                end
                knnsm_pkg::ST_HOLD: begin
                    if (out_free) m_valid_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == knnsm_pkg::ST_HOLD && out_free) begin
            m_data_reg <= quo_reg[7:0];
            m_last_reg <= flast_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    a_calc_after_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == knnsm_pkg::ST_CALC |-> $past(state_reg) == knnsm_pkg::ST_IDLE)
        else $error("window update without an accepted item");
    a_valid_from_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == knnsm_pkg::ST_HOLD)
        else $error("result raised outside the output load");
    a_sum_range: assert property (@(posedge aclk) disable iff (!aresetn)
        acc_reg <= 12'd2295)
        else $error("k-smallest sum out of range");
    a_rem_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == knnsm_pkg::ST_DIV |-> rem_reg < k_eff)
        else $error("divide remainder not below divisor");
endmodule
